// ===== rtl/indexed_insert_delete_list_assert.svh =====
// Assertion helpers used by the list controller RTL.
`ifndef INDEXED_INSERT_DELETE_LIST_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_ASSERT_SVH

// Clocked property, checked outside reset.
`define IIDL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define IIDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iidl_pkg.sv =====
package iidl_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_SET_AT     = 3'd4,
    CMD_GET_AT     = 3'd5,
    CMD_READ_BACK  = 3'd6,
    CMD_READ_FRONT = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_SHIFT_UP   = 2'd2,
    OP_SHIFT_DOWN = 2'd3
  } cell_op_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] idx;
    logic             rd_en;
    logic [POS_W-1:0] rd_idx;
  } cell_ctl_t;

endpackage

// ===== rtl/iidl_cell.sv =====
module iidl_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                          clk_i,
  input  iidl_pkg::cell_ctl_t           ctl_i,
  input  logic [iidl_pkg::WORD_W-1:0]   word_i,
  input  logic [iidl_pkg::WORD_W-1:0]   prev_i,
  input  logic [iidl_pkg::WORD_W-1:0]   next_i,
  input  logic [iidl_pkg::WORD_W-1:0]   rd_i,
  output logic [iidl_pkg::WORD_W-1:0]   data_o,
  output logic [iidl_pkg::WORD_W-1:0]   rd_o
);

  localparam logic [iidl_pkg::POS_W-1:0] MyIdx = iidl_pkg::POS_W'(Index);

  logic [iidl_pkg::WORD_W-1:0] data_q, data_d;
  logic                        hit, above;

  assign hit   = (MyIdx == ctl_i.idx);
  assign above = (MyIdx > ctl_i.idx);

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      iidl_pkg::OP_HOLD: ;
      iidl_pkg::OP_WRITE: begin
        if (hit) data_d = word_i;
      end
      iidl_pkg::OP_SHIFT_UP: begin
        // open a gap at idx: take the word there, move the tail up
        if (hit) data_d = word_i;
        else if (above) data_d = prev_i;
      end
      iidl_pkg::OP_SHIFT_DOWN: begin
        // close the gap at idx: pull the tail down
        if (hit || above) data_d = next_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // read select chain: the addressed cell merges its word in, others pass on
  assign rd_o   = rd_i | ((ctl_i.rd_en && (MyIdx == ctl_i.rd_idx)) ? data_q : '0);

endmodule

// ===== rtl/iidl_ctrl.sv =====
`include "indexed_insert_delete_list_assert.svh"

module iidl_ctrl #(
  parameter int unsigned Depth = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  iidl_pkg::cmd_e              cmd_i,
  input  logic [iidl_pkg::POS_W-1:0]  position_i,
  output iidl_pkg::cell_ctl_t         ctl_o,
  output iidl_pkg::status_e           status_o,
  output logic [$clog2(Depth+1)-1:0]  fill_d_o
);

  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CW > iidl_pkg::POS_W) ? CW : iidl_pkg::POS_W;

  logic [CW-1:0]   fill_q, fill_d;
  logic [CmpW-1:0] fill_ext, last_ext, pos_ext, ins_idx, clamp_idx;
  logic            empty, full;

  assign empty    = (fill_q == '0);
  assign full     = (fill_q == CW'(Depth));
  assign fill_ext = CmpW'(fill_q);
  assign last_ext = fill_ext - CmpW'(1);
  assign pos_ext  = CmpW'(position_i);
  assign ins_idx   = (pos_ext >= fill_ext) ? fill_ext : pos_ext;
  assign clamp_idx = (pos_ext >= last_ext) ? last_ext : pos_ext;

  always_comb begin
    fill_d       = fill_q;
    status_o     = iidl_pkg::ST_OK;
    ctl_o.op     = iidl_pkg::OP_HOLD;
    ctl_o.idx    = iidl_pkg::POS_W'(clamp_idx);
    ctl_o.rd_en  = 1'b0;
    ctl_o.rd_idx = iidl_pkg::POS_W'(clamp_idx);
    if (accept_i) begin
      unique case (cmd_i)
        iidl_pkg::CMD_PUSH_BACK: begin
          if (full) status_o = iidl_pkg::ST_FULL;
          else begin
            ctl_o.op  = iidl_pkg::OP_WRITE;
            ctl_o.idx = iidl_pkg::POS_W'(fill_ext);
            fill_d    = fill_q + CW'(1);
          end
        end
        iidl_pkg::CMD_POP_BACK: begin
          if (empty) status_o = iidl_pkg::ST_EMPTY;
          else fill_d = fill_q - CW'(1);
        end
        iidl_pkg::CMD_INSERT_AT: begin
          if (full) status_o = iidl_pkg::ST_FULL;
          else begin
            ctl_o.op  = iidl_pkg::OP_SHIFT_UP;
            ctl_o.idx = iidl_pkg::POS_W'(ins_idx);
            fill_d    = fill_q + CW'(1);
          end
        end
        iidl_pkg::CMD_REMOVE_AT: begin
          if (empty) status_o = iidl_pkg::ST_EMPTY;
          else begin
            ctl_o.op = iidl_pkg::OP_SHIFT_DOWN;
            fill_d   = fill_q - CW'(1);
          end
        end
        iidl_pkg::CMD_SET_AT: begin
          if (empty) status_o = iidl_pkg::ST_EMPTY;
          else ctl_o.op = iidl_pkg::OP_WRITE;
        end
        iidl_pkg::CMD_GET_AT: begin
          if (empty) status_o = iidl_pkg::ST_EMPTY;
          else ctl_o.rd_en = 1'b1;
        end
        iidl_pkg::CMD_READ_BACK: begin
          if (empty) status_o = iidl_pkg::ST_EMPTY;
          else begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_idx = iidl_pkg::POS_W'(last_ext);
          end
        end
        iidl_pkg::CMD_READ_FRONT: begin
          if (empty) status_o = iidl_pkg::ST_EMPTY;
          else begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_idx = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign fill_d_o = fill_d;

  `IIDL_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= CW'(Depth), "fill count above depth")
  `IIDL_ASSERT(a_fill_idle, clk_i, rst_ni, !accept_i |=> $stable(fill_q), "fill moved while idle")
  `IIDL_ASSERT_IMP(a_drop_hold, clk_i, rst_ni, accept_i && (status_o != iidl_pkg::ST_OK), fill_d == fill_q && ctl_o.op == iidl_pkg::OP_HOLD, "rejected beat changed the list")
  `IIDL_ASSERT_IMP(a_fill_step, clk_i, rst_ni, accept_i, fill_d == fill_q || fill_d == fill_q + CW'(1) || fill_d == fill_q - CW'(1), "fill moved by more than one")

endmodule

// ===== rtl/indexed_insert_delete_list.sv =====
// Ordered list of up to DEPTH signed 32-bit words with push/pop at the back, insert, remove,
// set and get at an index, and back/front reads; every command beat returns one result beat
// carrying the word read, the element count after the command and a status (ok, empty, full).
// Each element lives in its own cell of a row; insert and remove move the whole tail by one
// cell in the same clock, so every command completes as it is taken and the result appears in
// the output register on the next cycle. One command is taken per clock while the result
// side keeps up; a held result stalls the input only when a new beat would overwrite it.
// Reads of a chosen index travel along a select chain through all DEPTH cells.
module indexed_insert_delete_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [2:0]                            cmd_i,
  input  logic [iidl_pkg::POS_W-1:0]            position_i,
  input  logic signed [iidl_pkg::WORD_W-1:0]    word_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [iidl_pkg::WORD_W-1:0]    word_out_o,
  output logic [iidl_pkg::COUNT_W-1:0]          count_o,
  output logic [1:0]                            status_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                         accept;
  iidl_pkg::cell_ctl_t          ctl;
  iidl_pkg::status_e            status;
  logic [CW-1:0]                fill_d;
  logic [iidl_pkg::WORD_W-1:0]  data [DEPTH];
  logic [iidl_pkg::WORD_W-1:0]  rd_chain [DEPTH+1];

  logic                         out_valid_q;
  logic [iidl_pkg::WORD_W-1:0]  word_out_q;
  logic [iidl_pkg::COUNT_W-1:0] count_q;
  logic [1:0]                   status_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  iidl_ctrl #(
    .Depth (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (iidl_pkg::cmd_e'(cmd_i)),
    .position_i (position_i),
    .ctl_o      (ctl),
    .status_o   (status),
    .fill_d_o   (fill_d)
  );

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [iidl_pkg::WORD_W-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = word_in_i;
    end else begin : g_mid_lo
      assign prev = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next = data[i];
    end else begin : g_mid_hi
      assign next = data[i+1];
    end

    iidl_cell #(
      .Index (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .word_i (word_in_i),
      .prev_i (prev),
      .next_i (next),
      .rd_i   (rd_chain[i]),
      .data_o (data[i]),
      .rd_o   (rd_chain[i+1])
    );
  end

  // result register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_out_q <= rd_chain[DEPTH];
      count_q    <= iidl_pkg::COUNT_W'(fill_d);
      status_q   <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = word_out_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule
